// ===== sv/vrt_pkg.sv =====
// Package for the voxel ray traversal unit: command and status structs, controller states,
// result kinds and the sine polynomial coefficients. No dependencies.
`default_nettype none
package vrt_pkg;

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;
    localparam logic [1:0] KIND_NORAY = 2'd3;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] T_ONES  = 32'hFFFF_FFFF;

    localparam logic [31:0] SIN_COEF [5] = '{
        32'd1686629713, 32'd693598668, 32'd85569304, 32'd5026995, 32'd172273
    };

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DISP  = 11'b000_0000_0010,
        S_SIN   = 11'b000_0000_0100,
        S_DIV   = 11'b000_0000_1000,
        S_RINIT = 11'b000_0001_0000,
        S_RITER = 11'b000_0010_0000,
        S_RDONE = 11'b000_0100_0000,
        S_TNEXT = 11'b000_1000_0000,
        S_RSQ   = 11'b001_0000_0000,
        S_RDEC  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_SIN, OP_DIV, OP_RINIT, OP_RITER, OP_RDONE, OP_TNEXT,
        OP_RSQ, OP_RDEC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic [2:0] sub;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== sv/vrt_ctrl.sv =====
// Controller state machine of the voxel ray traversal unit.
// Sequences setup and reply steps for the datapath; depends on vrt_pkg.
`default_nettype none
module vrt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire vrt_pkg::t_status i_status,
    output vrt_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    vrt_pkg::t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrt_pkg::S_IDLE;
            r_idx   <= 2'd0;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        o_cmd.op   = vrt_pkg::OP_NOP;
        o_cmd.idx  = r_idx;
        o_cmd.sub  = r_cnt[2:0];
        o_cmd.emit = 1'b0;
        case (r_state)
            vrt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = vrt_pkg::OP_LOAD;
                    n_state  = vrt_pkg::S_DISP;
                end
            end
            vrt_pkg::S_DISP: begin
                n_idx   = 2'd0;
                n_cnt   = 5'd0;
                n_state = i_status.action ? vrt_pkg::S_RSQ : vrt_pkg::S_SIN;
            end
            vrt_pkg::S_SIN: begin
                o_cmd.op = vrt_pkg::OP_SIN;
                if (r_cnt == 5'd6) begin
                    n_cnt = 5'd0;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = vrt_pkg::S_DIV;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            vrt_pkg::S_DIV: begin
                o_cmd.op = vrt_pkg::OP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd1) begin
                    n_idx   = 2'd0;
                    n_state = vrt_pkg::S_RINIT;
                end
            end
            vrt_pkg::S_RINIT: begin
                o_cmd.op = vrt_pkg::OP_RINIT;
                n_cnt    = 5'd0;
                n_state  = vrt_pkg::S_RITER;
            end
            vrt_pkg::S_RITER: begin
                o_cmd.op = vrt_pkg::OP_RITER;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = vrt_pkg::S_RDONE;
                end
            end
            vrt_pkg::S_RDONE: begin
                o_cmd.op = vrt_pkg::OP_RDONE;
                n_state  = vrt_pkg::S_TNEXT;
            end
            vrt_pkg::S_TNEXT: begin
                o_cmd.op = vrt_pkg::OP_TNEXT;
                if (r_idx == 2'd2) begin
                    n_state = vrt_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = vrt_pkg::S_RINIT;
                end
            end
            vrt_pkg::S_RSQ: begin
                o_cmd.op = vrt_pkg::OP_RSQ;
                if (r_idx == 2'd2) begin
                    n_state = vrt_pkg::S_RDEC;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            vrt_pkg::S_RDEC: begin
                o_cmd.op = vrt_pkg::OP_RDEC;
                n_state  = vrt_pkg::S_EMIT;
            end
            vrt_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = vrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vrt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != vrt_pkg::S_IDLE);

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrt_pkg::S_EMIT && !i_status.out_free) |=> (r_state == vrt_pkg::S_EMIT))
        else $error("emit state left while the output register was full");

    a_riter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrt_pkg::S_RDONE) |-> ($past(r_state) == vrt_pkg::S_RITER
                                          && $past(r_cnt) == 5'd31))
        else $error("reciprocal finished without a full set of iterations");

endmodule
`default_nettype wire

// ===== sv/vrt_datapath.sv =====
// Datapath of the voxel ray traversal unit: shared multiplier, sine polynomial, reciprocal
// divider, DDA state and output register. Driven by vrt_ctrl; depends on vrt_pkg.
`default_nettype none
module vrt_datapath #(
    parameter int POS_FRAC_BITS = 8,
    parameter int ANGLE_BITS    = 16,
    parameter int T_FRAC_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire vrt_pkg::t_cmd      i_cmd,
    output vrt_pkg::t_status        o_status,
    input  wire logic               i_cfg_valid,
    input  wire logic [11:0]        i_cfg_data,
    input  wire logic               i_action,
    input  wire logic signed [23:0] i_cam_x,
    input  wire logic signed [23:0] i_cam_y,
    input  wire logic signed [23:0] i_cam_z,
    input  wire logic [15:0]        i_yaw_angle,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic               i_is_solid,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [1:0]              o_kind,
    output logic signed [15:0]      o_voxel_x,
    output logic signed [15:0]      o_voxel_y,
    output logic signed [15:0]      o_voxel_z,
    output logic signed [15:0]      o_before_x,
    output logic signed [15:0]      o_before_y,
    output logic signed [15:0]      o_before_z
);

    localparam int P = POS_FRAC_BITS;
    localparam logic [31:0] AMASK   = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic signed [31:0] QUARTER = 32'(64'd1 << (ANGLE_BITS - 2));
    localparam logic [31:0] REM_INIT = 32'(64'd1 << (T_FRAC_BITS - 2));
    localparam logic [P:0]  DIST_ONE = (P + 1)'(1 << P);

    logic        r_active;
    logic        r_action;
    logic        r_solid;
    logic [11:0] r_limit;
    logic [31:0] r_yaw, r_pitch;
    logic [15:0] r_cur [3];
    logic [15:0] r_prev [3];
    logic [15:0] r_orig [3];
    logic        r_neg [3];
    logic [P-1:0] r_frac [3];
    logic [31:0] r_tnext [3];
    logic [31:0] r_tdelta [3];
    logic [30:0] r_sin [4];
    logic [30:0] r_div [3];
    logic [30:0] r_r, r_x2;
    logic [31:0] r_t;
    logic [31:0] r_rem, r_quo;
    logic        r_sat;
    logic [34:0] r_d2;
    logic [1:0]  r_res_kind;
    logic [15:0] r_res_vox [3];
    logic [15:0] r_res_bef [3];

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] ang;
    logic [2:0]  coef_idx;
    logic [31:0] sin_s;
    logic [32:0] rem2;
    logic        rem_ge;
    logic [P:0]  step_len;
    logic signed [16:0] dd;
    logic [16:0] dd_abs;
    logic [1:0]  axis;
    logic [15:0] cur_step;
    logic [32:0] tsum;
    logic signed [31:0] p_ext, p_clamp;
    logic [31:0] yaw_in;
    logic signed [23:0] cams [3];
    logic        start_neg [3];

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (i_cmd.idx)
            2'd0:    ang = r_yaw;
            2'd1:    ang = r_yaw + vrt_pkg::ONE_Q30;
            2'd2:    ang = r_pitch;
            default: ang = r_pitch + vrt_pkg::ONE_Q30;
        endcase
        coef_idx = 3'd5 - i_cmd.sub;
        step_len = r_neg[i_cmd.idx] ? {1'b0, r_frac[i_cmd.idx]}
                                    : DIST_ONE - {1'b0, r_frac[i_cmd.idx]};
        dd = $signed({r_cur[i_cmd.idx][15], r_cur[i_cmd.idx]})
           - $signed({r_orig[i_cmd.idx][15], r_orig[i_cmd.idx]});
        dd_abs = dd[16] ? 17'(-dd) : 17'(dd);
        mul_a = r_t;
        mul_b = 32'(r_x2);
        case (i_cmd.op)
            vrt_pkg::OP_SIN: begin
                if (i_cmd.sub == 3'd1) begin
                    mul_a = 32'(r_r);
                    mul_b = 32'(r_r);
                end else if (i_cmd.sub == 3'd6) begin
                    mul_b = 32'(r_r);
                end
            end
            vrt_pkg::OP_DIV: begin
                mul_a = 32'(r_sin[3]);
                mul_b = i_cmd.sub[0] ? 32'(r_sin[1]) : 32'(r_sin[0]);
            end
            vrt_pkg::OP_TNEXT: begin
                mul_a = 32'(step_len);
                mul_b = r_tdelta[i_cmd.idx];
            end
            vrt_pkg::OP_RSQ: begin
                mul_a = 32'(dd_abs);
                mul_b = 32'(dd_abs);
            end
            default: begin
                mul_a = r_t;
            end
        endcase
        sin_s = 32'(mul_p >> 30);
        if (sin_s > vrt_pkg::ONE_Q30) begin
            sin_s = vrt_pkg::ONE_Q30;
        end
        rem2   = {r_rem, 1'b0};
        rem_ge = (rem2 >= 33'(r_div[i_cmd.idx]));
        if (r_tnext[0] < r_tnext[1]) begin
            axis = (r_tnext[0] < r_tnext[2]) ? 2'd0 : 2'd2;
        end else begin
            axis = (r_tnext[1] < r_tnext[2]) ? 2'd1 : 2'd2;
        end
        cur_step = r_cur[axis] + (r_neg[axis] ? 16'hFFFF : 16'd1);
        tsum = 33'(r_tnext[axis]) + 33'(r_tdelta[axis]);
        p_ext = 32'(i_pitch_angle);
        p_clamp = p_ext;
        if (p_ext > QUARTER) begin
            p_clamp = QUARTER;
        end else if (p_ext < -QUARTER) begin
            p_clamp = -QUARTER;
        end
        yaw_in = (32'(i_yaw_angle) & AMASK) << (32 - ANGLE_BITS);
        cams[0] = i_cam_x;
        cams[1] = i_cam_y;
        cams[2] = i_cam_z;
        start_neg[0] = !yaw_in[31];
        start_neg[1] = p_clamp[31];
        start_neg[2] = (yaw_in < vrt_pkg::ONE_Q30) || (yaw_in > 32'hC000_0000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_action    <= 1'b0;
            r_limit     <= 12'd25;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.op == vrt_pkg::OP_LOAD) begin
                r_action <= i_action;
                if (!i_action) begin
                    r_active <= 1'b1;
                end
            end
            if (i_cmd.op == vrt_pkg::OP_RDEC && r_active
                    && (r_solid || r_d2 >= 35'(r_limit))) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind     <= r_res_kind;
            o_voxel_x  <= r_res_vox[0];
            o_voxel_y  <= r_res_vox[1];
            o_voxel_z  <= r_res_vox[2];
            o_before_x <= r_res_bef[0];
            o_before_y <= r_res_bef[1];
            o_before_z <= r_res_bef[2];
        end
        case (i_cmd.op)
            vrt_pkg::OP_LOAD: begin
                r_solid <= i_is_solid;
                if (!i_action) begin
                    r_yaw   <= yaw_in;
                    r_pitch <= 32'(p_clamp << (32 - ANGLE_BITS));
                    r_res_kind <= vrt_pkg::KIND_PROBE;
                    for (int i = 0; i < 3; i++) begin
                        r_cur[i]     <= 16'(cams[i] >>> P);
                        r_prev[i]    <= 16'(cams[i] >>> P);
                        r_orig[i]    <= 16'(cams[i] >>> P);
                        r_res_vox[i] <= 16'(cams[i] >>> P);
                        r_res_bef[i] <= 16'd0;
                        r_frac[i]    <= cams[i][P-1:0];
                        r_neg[i]     <= start_neg[i];
                    end
                end
            end
            vrt_pkg::OP_SIN: begin
                if (i_cmd.sub == 3'd0) begin
                    r_r <= ang[30] ? 31'(vrt_pkg::ONE_Q30) - {1'b0, ang[29:0]}
                                   : {1'b0, ang[29:0]};
                end else if (i_cmd.sub == 3'd1) begin
                    r_x2 <= 31'(mul_p >> 30);
                    r_t  <= vrt_pkg::SIN_COEF[4];
                end else if (i_cmd.sub == 3'd6) begin
                    r_sin[i_cmd.idx] <= 31'(sin_s);
                end else begin
                    r_t <= vrt_pkg::SIN_COEF[coef_idx] - 32'(mul_p >> 30);
                end
            end
            vrt_pkg::OP_DIV: begin
                r_div[1] <= r_sin[2];
                if (i_cmd.sub[0]) begin
                    r_div[2] <= 31'(mul_p >> 30);
                end else begin
                    r_div[0] <= 31'(mul_p >> 30);
                end
            end
            vrt_pkg::OP_RINIT: begin
                r_rem <= REM_INIT;
                r_quo <= 32'd0;
                r_sat <= (32'(r_div[i_cmd.idx]) <= REM_INIT);
            end
            vrt_pkg::OP_RITER: begin
                r_rem <= rem_ge ? 32'(rem2 - 33'(r_div[i_cmd.idx])) : 32'(rem2);
                r_quo <= {r_quo[30:0], rem_ge};
            end
            vrt_pkg::OP_RDONE: begin
                r_tdelta[i_cmd.idx] <= r_sat ? vrt_pkg::T_ONES : r_quo;
            end
            vrt_pkg::OP_TNEXT: begin
                r_tnext[i_cmd.idx] <= (r_tdelta[i_cmd.idx] == vrt_pkg::T_ONES)
                                      ? vrt_pkg::T_ONES : 32'(mul_p >> P);
            end
            vrt_pkg::OP_RSQ: begin
                r_d2 <= ((i_cmd.idx == 2'd0) ? 35'd0 : r_d2) + 35'(mul_p);
            end
            vrt_pkg::OP_RDEC: begin
                if (!r_active) begin
                    r_res_kind <= vrt_pkg::KIND_NORAY;
                    for (int i = 0; i < 3; i++) begin
                        r_res_vox[i] <= 16'd0;
                        r_res_bef[i] <= 16'd0;
                    end
                end else if (r_solid) begin
                    r_res_kind <= vrt_pkg::KIND_HIT;
                    for (int i = 0; i < 3; i++) begin
                        r_res_vox[i] <= r_cur[i];
                        r_res_bef[i] <= r_prev[i];
                    end
                end else if (r_d2 >= 35'(r_limit)) begin
                    r_res_kind <= vrt_pkg::KIND_MISS;
                    for (int i = 0; i < 3; i++) begin
                        r_res_vox[i] <= r_cur[i];
                        r_res_bef[i] <= 16'd0;
                    end
                end else begin
                    r_res_kind <= vrt_pkg::KIND_PROBE;
                    for (int i = 0; i < 3; i++) begin
                        r_prev[i]    <= r_cur[i];
                        r_res_bef[i] <= 16'd0;
                        if (2'(i) == axis) begin
                            r_cur[i]     <= cur_step;
                            r_res_vox[i] <= cur_step;
                        end else begin
                            r_res_vox[i] <= r_cur[i];
                        end
                    end
                    r_tnext[axis] <= tsum[32] ? vrt_pkg::T_ONES : tsum[31:0];
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_status.action   = r_action;
    assign o_status.out_free = !o_out_valid || !i_out_stall;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.out_free)
        else $error("result loaded over a waiting beat");

    a_one_axis_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.op) == vrt_pkg::OP_RDEC && r_res_kind == vrt_pkg::KIND_PROBE)
        |-> $countones({r_cur[0] != r_prev[0], r_cur[1] != r_prev[1],
                        r_cur[2] != r_prev[2]}) == 1)
        else $error("walk step moved other than exactly one axis");

    a_ray_starts_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> ($past(i_cmd.op) == vrt_pkg::OP_LOAD))
        else $error("ray became active without a start beat");

endmodule
`default_nettype wire

// ===== sv/voxel_ray_traversal_unit.sv =====
// Top level of the voxel ray traversal unit: controller plus datapath.
// Depends on vrt_pkg, vrt_ctrl and vrt_datapath.
//
//   channel | direction | handshake                 | payload
//   in      | to block  | i_in_valid / o_in_stall   | action, cam_x/y/z, yaw, pitch, is_solid
//   out     | from block| o_out_valid / i_out_stall | kind, voxel_x/y/z, before_x/y/z
//   cfg     | to block  | i_cfg_valid / o_cfg_ready | range_limit_sq
//
// A start beat is worked through in order before its result is loaded: four sine evaluations on
// the shared multiplier, the divisors, and a bit-serial reciprocal for each axis.
// A reply beat is mostly the three squared offsets on the same multiplier.
// A full output register holds the controller in its last step; a new beat is taken as soon
// as the result has moved into the output register. Reset is synchronous, active low.
`default_nettype none
module voxel_ray_traversal_unit #(
    parameter int POS_FRAC_BITS = 8,
    parameter int ANGLE_BITS    = 16,
    parameter int T_FRAC_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_action,
    input  wire logic signed [23:0] i_cam_x,
    input  wire logic signed [23:0] i_cam_y,
    input  wire logic signed [23:0] i_cam_z,
    input  wire logic [15:0]        i_yaw_angle,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic               i_is_solid,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_kind,
    output logic signed [15:0]      o_voxel_x,
    output logic signed [15:0]      o_voxel_y,
    output logic signed [15:0]      o_voxel_z,
    output logic signed [15:0]      o_before_x,
    output logic signed [15:0]      o_before_y,
    output logic signed [15:0]      o_before_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [11:0]        i_cfg_data
);

    vrt_pkg::t_cmd    cmd;
    vrt_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    vrt_datapath #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .T_FRAC_BITS   (T_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_cam_x       (i_cam_x),
        .i_cam_y       (i_cam_y),
        .i_cam_z       (i_cam_z),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_is_solid    (i_is_solid),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_voxel_x     (o_voxel_x),
        .o_voxel_y     (o_voxel_y),
        .o_voxel_z     (o_voxel_z),
        .o_before_x    (o_before_x),
        .o_before_y    (o_before_y),
        .o_before_z    (o_before_z)
    );

endmodule
`default_nettype wire

// ===== test/tb_voxel_ray_traversal_unit.sv =====
// Self-checking testbench for voxel_ray_traversal_unit: random camera rays and solidity
// replies, checked beat by beat against a DDA walk predictor. Depends on vrt_pkg.
`default_nettype none
module tb_voxel_ray_traversal_unit;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_REPLY = 1'b1;
    localparam int   SETTLE    = 150;

    typedef struct packed {
        logic        action;
        logic [23:0] cx, cy, cz;
        logic [15:0] yaw, pitch;
        logic        solid;
    } t_ray_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vx, vy, vz, bx, by, bz;
    } t_walk_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, i_action = 0, i_is_solid = 0;
    logic signed [23:0] i_cam_x = 0, i_cam_y = 0, i_cam_z = 0;
    logic [15:0] i_yaw_angle = 0;
    logic signed [15:0] i_pitch_angle = 0;
    logic i_out_stall = 1, i_cfg_valid = 0;
    logic [11:0] i_cfg_data = 0;
    logic o_in_stall, o_out_valid, o_cfg_ready;
    logic [1:0] o_kind;
    logic signed [15:0] o_voxel_x, o_voxel_y, o_voxel_z, o_before_x, o_before_y, o_before_z;

    voxel_ray_traversal_unit dut (.*);

    t_ray_cmd  pending_cmds[$];
    t_walk_res expected_res[$];
    int  fail_count = 0;
    bit  in_took = 0, out_took = 0, cfg_took = 0, quiet = 0;
    int  send_gap = 0, stall_left = 0;

    // Shadow of the walk state.
    logic [11:0] limit_sq = 25;
    bit          walking = 0;
    logic [15:0] cur_v[3], prev_v[3], org_v[3];
    bit          neg_step[3];
    logic [31:0] t_nxt[3], t_dlt[3];

    initial begin
        for (int i = 0; i < 3; i++) begin
            cur_v[i] = 0; prev_v[i] = 0; org_v[i] = 0;
            neg_step[i] = 0; t_nxt[i] = 0; t_dlt[i] = 0;
        end
    end

    initial forever #5 i_clk = ~i_clk;

    function automatic logic [63:0] sine_abs(logic [31:0] u);
        logic [63:0] r, x2, t, s;
        r = {34'd0, u[29:0]};
        if (u[30]) r = 64'(vrt_pkg::ONE_Q30) - r;
        x2 = (r * r) >> 30;
        t = 64'(vrt_pkg::SIN_COEF[4]);
        for (int k = 3; k >= 0; k--) t = 64'(vrt_pkg::SIN_COEF[k]) - ((t * x2) >> 30);
        s = (t * r) >> 30;
        return (s > 64'(vrt_pkg::ONE_Q30)) ? 64'(vrt_pkg::ONE_Q30) : s;
    endfunction

    function automatic logic [31:0] inv_step(logic [63:0] d);
        logic [63:0] q;
        if (d == 0) return vrt_pkg::T_ONES;
        q = (64'd1 << 46) / d;
        return (q > 64'(vrt_pkg::T_ONES)) ? vrt_pkg::T_ONES : q[31:0];
    endfunction

    function automatic t_walk_res walk_step(t_ray_cmd c);
        t_walk_res res;
        logic [31:0] yaw32, pitch32;
        int p, ax;
        logic [63:0] sy, cy, sp, cp, dv[3], step_len, tn, sum;
        logic [23:0] pos[3];
        logic signed [23:0] fl;
        longint d, d2;
        res = '0;
        if (c.action == ACT_START) begin
            yaw32 = {c.yaw, 16'd0};
            p = $signed(c.pitch);
            if (p > 16384) p = 16384;
            if (p < -16384) p = -16384;
            pitch32 = 32'(p) << 16;
            sy = sine_abs(yaw32); cy = sine_abs(yaw32 + vrt_pkg::ONE_Q30);
            sp = sine_abs(pitch32); cp = sine_abs(pitch32 + vrt_pkg::ONE_Q30);
            dv[0] = (cp * sy) >> 30; dv[1] = sp; dv[2] = (cp * cy) >> 30;
            neg_step[0] = yaw32 < 32'h8000_0000;
            neg_step[1] = p < 0;
            neg_step[2] = (yaw32 < vrt_pkg::ONE_Q30) || (yaw32 > 32'hC000_0000);
            pos[0] = c.cx; pos[1] = c.cy; pos[2] = c.cz;
            for (int i = 0; i < 3; i++) begin
                fl = $signed(pos[i]) >>> 8;
                step_len = neg_step[i] ? 64'(pos[i][7:0]) : 64'd256 - 64'(pos[i][7:0]);
                t_dlt[i] = inv_step(dv[i]);
                tn = (step_len * 64'(t_dlt[i])) >> 8;
                t_nxt[i] = (t_dlt[i] == vrt_pkg::T_ONES) ? vrt_pkg::T_ONES : tn[31:0];
                cur_v[i] = fl[15:0]; prev_v[i] = fl[15:0]; org_v[i] = fl[15:0];
            end
            walking = 1;
            res.kind = vrt_pkg::KIND_PROBE;
        end else if (!walking) begin
            res.kind = vrt_pkg::KIND_NORAY;
            return res;
        end else if (c.solid) begin
            walking = 0;
            res.kind = vrt_pkg::KIND_HIT;
            res.bx = prev_v[0]; res.by = prev_v[1]; res.bz = prev_v[2];
        end else begin
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
                d = longint'($signed(cur_v[i])) - longint'($signed(org_v[i]));
                d2 += d * d;
            end
            if (d2 >= longint'(limit_sq)) begin
                walking = 0;
                res.kind = vrt_pkg::KIND_MISS;
            end else begin
                for (int i = 0; i < 3; i++) prev_v[i] = cur_v[i];
                if (t_nxt[0] < t_nxt[1]) ax = (t_nxt[0] < t_nxt[2]) ? 0 : 2;
                else ax = (t_nxt[1] < t_nxt[2]) ? 1 : 2;
                cur_v[ax] = neg_step[ax] ? cur_v[ax] - 16'd1 : cur_v[ax] + 16'd1;
                sum = 64'(t_nxt[ax]) + 64'(t_dlt[ax]);
                t_nxt[ax] = (sum > 64'(vrt_pkg::T_ONES)) ? vrt_pkg::T_ONES : sum[31:0];
                res.kind = vrt_pkg::KIND_PROBE;
            end
        end
        res.vx = cur_v[0]; res.vy = cur_v[1]; res.vz = cur_v[2];
        return res;
    endfunction

    // Monitor: predicts on every accepted input beat, checks every output beat.
    always @(posedge i_clk) begin
        t_walk_res e;
        in_took  <= i_in_valid && !o_in_stall;
        out_took <= o_out_valid && !i_out_stall;
        cfg_took <= i_cfg_valid && o_cfg_ready;
        if (i_cfg_valid && o_cfg_ready) limit_sq = i_cfg_data;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_res.push_back(walk_step({i_action, i_cam_x, i_cam_y, i_cam_z,
                                              i_yaw_angle, i_pitch_angle, i_is_solid}));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_res.size() == 0) begin
                $error("output beat with no expected result");
                fail_count++;
            end else begin
                e = expected_res.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind); fail_count++;
                end
                if (o_voxel_x !== e.vx) begin
                    $error("voxel_x: expected %0d, got %0d", $signed(e.vx), o_voxel_x);
                    fail_count++;
                end
                if (o_voxel_y !== e.vy) begin
                    $error("voxel_y: expected %0d, got %0d", $signed(e.vy), o_voxel_y);
                    fail_count++;
                end
                if (o_voxel_z !== e.vz) begin
                    $error("voxel_z: expected %0d, got %0d", $signed(e.vz), o_voxel_z);
                    fail_count++;
                end
                if (o_before_x !== e.bx) begin
                    $error("before_x: expected %0d, got %0d", $signed(e.bx), o_before_x);
                    fail_count++;
                end
                if (o_before_y !== e.by) begin
                    $error("before_y: expected %0d, got %0d", $signed(e.by), o_before_y);
                    fail_count++;
                end
                if (o_before_z !== e.bz) begin
                    $error("before_z: expected %0d, got %0d", $signed(e.bz), o_before_z);
                    fail_count++;
                end
            end
        end
    end

    // Input driver.
    always @(negedge i_clk) begin
        t_ray_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (i_in_valid && !in_took) begin
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 0;
        end else if (pending_cmds.size() != 0) begin
            c = pending_cmds.pop_front();
            i_action <= c.action; i_cam_x <= c.cx; i_cam_y <= c.cy; i_cam_z <= c.cz;
            i_yaw_angle <= c.yaw; i_pitch_angle <= c.pitch; i_is_solid <= c.solid;
            i_in_valid <= 1;
            send_gap = quiet ? 0 : $urandom_range(0, 14);
        end else begin
            i_in_valid <= 0;
        end
    end

    // Output stall generator.
    always @(negedge i_clk) begin
        if (out_took) stall_left = quiet ? 0 : $urandom_range(0, 14);
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    function automatic logic [23:0] pick_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 24'($signed($urandom_range(0, 4095)) - 2048);
            2: return 24'h7FFF00 | 24'($urandom_range(0, 255));
            default: return 24'h800000 | 24'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_start(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                               logic [15:0] yaw, logic [15:0] pitch);
        pending_cmds.push_back({ACT_START, x, y, z, yaw, pitch, logic'($urandom_range(0, 1))});
    endtask

    task automatic queue_reply(logic solid);
        pending_cmds.push_back({ACT_REPLY, 24'($urandom), 24'($urandom), 24'($urandom),
                                16'($urandom), 16'($urandom), solid});
    endtask

    task automatic queue_random_ray();
        logic [15:0] yaw, pitch;
        yaw = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3) * 16384) : 16'($urandom);
        case ($urandom_range(0, 5))
            0: pitch = 16'($urandom);
            1: pitch = 0;
            default: pitch = 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
        queue_start(pick_pos(), pick_pos(), pick_pos(), yaw, pitch);
        for (int n = $urandom_range(0, 24); n > 0; n--)
            queue_reply($urandom_range(0, 9) == 0);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [11:0] v);
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        do @(negedge i_clk); while (!cfg_took);
        i_cfg_valid <= 0;
    endtask

    initial begin
        logic [11:0] limits[6];
        int added;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part.
        queue_reply(0);
        queue_reply(1);
        queue_start(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'd0, 16'd0);
        repeat (4) queue_reply(0);
        queue_start(24'h800000, 24'h800000, 24'h800000, 16'd16384, 16'd16384);
        repeat (3) queue_reply(0);
        queue_start(24'h000080, 24'hFFFF80, 24'h000000, 16'd32768, 16'h8000);
        queue_reply(0);
        queue_start(24'h0001FF, 24'h000100, 24'hFFFFFF, 16'd49152, 16'h7FFF);
        repeat (2) queue_reply(0);
        queue_reply(1);
        queue_reply(0);
        queue_start(24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 16'hC000);
        queue_reply(1);
        drain();

        limits = '{12'd0, 12'd1, 12'd4095, 12'($urandom_range(2, 4094)), 12'd3, 12'd25};
        foreach (limits[k]) begin
            write_limit(limits[k]);
            quiet = (k == 4);
            added = 0;
            while (added < 80) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_reply($urandom_range(0, 1));
                    added++;
                end else begin
                    added -= pending_cmds.size();
                    queue_random_ray();
                    added += pending_cmds.size();
                end
            end
            drain();
        end

        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
sv/vrt_pkg.sv
sv/vrt_ctrl.sv
sv/vrt_datapath.sv
sv/voxel_ray_traversal_unit.sv
test/tb_voxel_ray_traversal_unit.sv
